// File: hw/rtl/vvi_pkg.sv
// ----------------------------------------------------------------------------
// vvi_pkg
// Shared types, register codes and helpers for the Verlet vertex integrator.
// ----------------------------------------------------------------------------
package vvi_pkg;

    localparam int NUM_STG   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;
    localparam int WIDE_W    = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_EN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HGT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG      = 3'd7;

    localparam logic [30:0] RST_BOX_DIM = 31'd52428800;
    localparam logic [31:0] RST_GRAVITY = 32'd655;
    localparam logic [17:0] RST_DAMPING = 18'd65536;
    localparam logic [16:0] RST_DRAG    = 17'd6554;

    typedef struct packed {
        logic        bound_en;
        logic [31:0] box_left;
        logic [31:0] box_top;
        logic [30:0] box_width;
        logic [30:0] box_height;
        logic [31:0] gravity;
        logic [17:0] damping;
        logic [16:0] drag;
    } t_cfg;

    typedef struct packed {
        logic [NUM_STG-1:0] load;
    } t_pipe_ctrl;

    function automatic logic [WIDE_W-1:0] sx32(input logic [31:0] v);
        sx32 = {{(WIDE_W-32){v[31]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic [WIDE_W-1:0] v);
        logic ovf;
        ovf = !((&v[WIDE_W-1:31]) || !(|v[WIDE_W-1:31]));
        if (ovf) begin
            sat32 = v[WIDE_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            sat32 = v[31:0];
        end
    endfunction

endpackage

// File: hw/rtl/verlet_vertex_integrate.sv
// ----------------------------------------------------------------------------
// verlet_vertex_integrate
// Position-Verlet step for one vertex per request, signed Q16.16, with
// optional world-box clamping and ground friction.
//
//   channel   direction  handshake              payload
//   vertex    in         i_valid / o_stall      cur_x cur_y prev_x prev_y pinned
//   result    out        o_valid / i_stall      next_x next_y last_x last_y
//   config    in         i_cfg_valid/o_cfg_ready i_cfg_index i_cfg_data
//
// One request per cycle while o_stall is low; the split 33x32 and
// 49x17 friction products are spread over the nine-stage pipeline.
// Reset clears the stage valid bits and loads the default registers.
// An empty stage always loads, so bubbles close up under output stall;
// o_stall rises only when all nine stages hold a request.
// ----------------------------------------------------------------------------
module verlet_vertex_integrate
    import vvi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic signed [31:0]   i_cur_x,
    input  logic signed [31:0]   i_cur_y,
    input  logic signed [31:0]   i_prev_x,
    input  logic signed [31:0]   i_prev_y,
    input  logic                 i_pinned,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic signed [31:0]   o_next_x,
    output logic signed [31:0]   o_next_y,
    output logic signed [31:0]   o_last_x,
    output logic signed [31:0]   o_last_y,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg       w_cfg;
    t_pipe_ctrl w_ctrl;

    vvi_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vvi_pipe_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctrl  (w_ctrl)
    );

    vvi_datapath u_dp (
        .i_clk    (i_clk),
        .i_cfg    (w_cfg),
        .i_ctrl   (w_ctrl),
        .i_cur_x  (i_cur_x),
        .i_cur_y  (i_cur_y),
        .i_prev_x (i_prev_x),
        .i_prev_y (i_prev_y),
        .i_pinned (i_pinned),
        .o_next_x (o_next_x),
        .o_next_y (o_next_y),
        .o_last_x (o_last_x),
        .o_last_y (o_last_y)
    );

endmodule

// File: hw/rtl/vvi_cfg_regs.sv
// ----------------------------------------------------------------------------
// vvi_cfg_regs
// Configuration register file for the integrator.
// ----------------------------------------------------------------------------
module vvi_cfg_regs
    import vvi_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound_en   <= 1'b0;
            r_cfg.box_left   <= '0;
            r_cfg.box_top    <= '0;
            r_cfg.box_width  <= RST_BOX_DIM;
            r_cfg.box_height <= RST_BOX_DIM;
            r_cfg.gravity    <= RST_GRAVITY;
            r_cfg.damping    <= RST_DAMPING;
            r_cfg.drag       <= RST_DRAG;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BOUND_EN:  r_cfg.bound_en   <= i_cfg_data[0];
                CFG_BOX_LEFT:  r_cfg.box_left   <= i_cfg_data;
                CFG_BOX_TOP:   r_cfg.box_top    <= i_cfg_data;
                CFG_BOX_WIDTH: r_cfg.box_width  <= i_cfg_data[30:0];
                CFG_BOX_HGT:   r_cfg.box_height <= i_cfg_data[30:0];
                CFG_GRAVITY:   r_cfg.gravity    <= i_cfg_data;
                CFG_DAMPING:   r_cfg.damping    <= i_cfg_data[17:0];
                CFG_DRAG:      r_cfg.drag       <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

endmodule

// File: hw/rtl/vvi_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// vvi_pipe_ctrl
// Valid tracking and per-stage load enables with bubble collapsing.
// ----------------------------------------------------------------------------
module vvi_pipe_ctrl
    import vvi_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output t_pipe_ctrl o_ctrl
);

    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG:0]   w_adv;
    logic [NUM_STG:0]   w_vin;

    assign w_adv[NUM_STG] = !i_stall;
    assign w_vin[0]       = i_valid;

    for (genvar k = 0; k < NUM_STG; k++) begin : g_stg
        assign w_adv[k]   = !r_vld[k] || w_adv[k+1];
        assign w_vin[k+1] = r_vld[k];
        assign n_vld[k]   = w_adv[k] ? w_vin[k] : r_vld[k];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_stall     = !w_adv[0];
    assign o_valid     = r_vld[NUM_STG-1];
    assign o_ctrl.load = w_adv[NUM_STG-1:0];

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_vld[0])
        else $error("accepted request did not enter first stage");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NUM_STG-1] && i_stall |=> r_vld[NUM_STG-1])
        else $error("stalled pipeline tail changed");

    for (genvar k = 0; k < NUM_STG-1; k++) begin : g_chk
        a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[k] && !w_adv[k+1] |=> r_vld[k])
            else $error("blocked stage lost its request");
    end

endmodule

// File: hw/rtl/vvi_datapath.sv
// ----------------------------------------------------------------------------
// vvi_datapath
// Nine-stage Verlet step: damping multiply, saturate, bound checks,
// split ground-friction products, clamp.
// ----------------------------------------------------------------------------
module vvi_datapath
    import vvi_pkg::*;
(
    input  logic        i_clk,
    input  t_cfg        i_cfg,
    input  t_pipe_ctrl  i_ctrl,
    input  logic [31:0] i_cur_x,
    input  logic [31:0] i_cur_y,
    input  logic [31:0] i_prev_x,
    input  logic [31:0] i_prev_y,
    input  logic        i_pinned,
    output logic [31:0] o_next_x,
    output logic [31:0] o_next_y,
    output logic [31:0] o_last_x,
    output logic [31:0] o_last_y
);

    typedef struct packed {
        logic [31:0] nx;
        logic [31:0] ny;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] bot;
        logic [32:0] right;
        logic        bnd;
        logic        lo;
        logic        hi;
        logic        neg;
    } t_carry;

    // stage 1
    logic signed [32:0] s1_dx, s1_dy;
    logic signed [18:0] s1_damp;
    logic signed [51:0] r_s1_mx, r_s1_my;
    logic [31:0]        r_s1_cx, r_s1_cy, r_s1_lx, r_s1_ly;
    logic               r_s1_pin;

    assign s1_dx   = $signed({i_cur_x[31], i_cur_x}) - $signed({i_prev_x[31], i_prev_x});
    assign s1_dy   = $signed({i_cur_y[31], i_cur_y}) - $signed({i_prev_y[31], i_prev_y});
    assign s1_damp = $signed({1'b0, i_cfg.damping});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[0]) begin
            r_s1_mx  <= s1_dx * s1_damp;
            r_s1_my  <= s1_dy * s1_damp;
            r_s1_cx  <= i_cur_x;
            r_s1_cy  <= i_cur_y;
            r_s1_lx  <= i_pinned ? i_prev_x : i_cur_x;
            r_s1_ly  <= i_pinned ? i_prev_y : i_cur_y;
            r_s1_pin <= i_pinned;
        end
    end

    // stage 2
    logic [51:0]       s2_rx, s2_ry;
    logic [35:0]       s2_qx, s2_qy;
    logic [WIDE_W-1:0] s2_sx, s2_sy;
    logic [31:0]       r_s2_nx, r_s2_ny, r_s2_cx, r_s2_lx, r_s2_ly;
    logic              r_s2_pin;

    assign s2_rx = r_s1_mx + {36'd0, {16{r_s1_mx[51]}}};
    assign s2_ry = r_s1_my + {36'd0, {16{r_s1_my[51]}}};
    assign s2_qx = s2_rx[51:16];
    assign s2_qy = s2_ry[51:16];
    assign s2_sx = sx32(r_s1_cx) + {{(WIDE_W-36){s2_qx[35]}}, s2_qx};
    assign s2_sy = sx32(r_s1_cy) + {{(WIDE_W-36){s2_qy[35]}}, s2_qy} + sx32(i_cfg.gravity);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[1]) begin
            r_s2_nx  <= r_s1_pin ? r_s1_cx : sat32(s2_sx);
            r_s2_ny  <= r_s1_pin ? r_s1_cy : sat32(s2_sy);
            r_s2_cx  <= r_s1_cx;
            r_s2_lx  <= r_s1_lx;
            r_s2_ly  <= r_s1_ly;
            r_s2_pin <= r_s1_pin;
        end
    end

    // stage 3
    logic [WIDE_W-1:0] s3_bot, s3_right, s3_ny, s3_top, s3_pen, s3_dn, s3_mag;
    logic              s3_bnd, s3_lo, s3_hi;
    logic [32:0]       r_s3_mag;
    logic [31:0]       r_s3_pen;
    t_carry            r_s3_c;

    assign s3_top   = sx32(i_cfg.box_top);
    assign s3_bot   = s3_top + {{(WIDE_W-31){1'b0}}, i_cfg.box_height};
    assign s3_right = sx32(i_cfg.box_left) + {{(WIDE_W-31){1'b0}}, i_cfg.box_width};
    assign s3_ny    = sx32(r_s2_ny);
    assign s3_bnd   = i_cfg.bound_en && !r_s2_pin;
    assign s3_lo    = $signed(s3_ny) < $signed(s3_top);
    assign s3_hi    = $signed(s3_ny) > $signed(s3_bot);
    assign s3_pen   = s3_ny - s3_bot;
    assign s3_dn    = sx32(r_s2_nx) - sx32(r_s2_cx);
    assign s3_mag   = s3_dn[WIDE_W-1] ? (~s3_dn + 1'b1) : s3_dn;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[2]) begin
            r_s3_mag       <= s3_mag[32:0];
            r_s3_pen       <= s3_pen[31:0];
            r_s3_c.nx      <= r_s2_nx;
            r_s3_c.ny      <= r_s2_ny;
            r_s3_c.lx      <= r_s2_lx;
            r_s3_c.ly      <= r_s2_ly;
            r_s3_c.bot     <= s3_bot[31:0];
            r_s3_c.right   <= s3_right[32:0];
            r_s3_c.bnd     <= s3_bnd;
            r_s3_c.lo      <= s3_bnd && s3_lo;
            r_s3_c.hi      <= s3_bnd && !s3_lo && s3_hi;
            r_s3_c.neg     <= s3_dn[WIDE_W-1];
        end
    end

    // stage 4: penetration product in two halves
    logic [48:0] r_s4_pl, r_s4_ph;
    t_carry      r_s4_c;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[3]) begin
            r_s4_pl <= r_s3_mag * r_s3_pen[15:0];
            r_s4_ph <= r_s3_mag * r_s3_pen[31:16];
            r_s4_c  <= r_s3_c;
        end
    end

    // stage 5
    logic [48:0] r_s5_tmag;
    t_carry      r_s5_c;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[4]) begin
            r_s5_tmag <= r_s4_ph + {16'd0, r_s4_pl[48:16]};
            r_s5_c    <= r_s4_c;
        end
    end

    // stage 6: friction product in two halves
    logic [48:0] r_s6_ul;
    logic [33:0] r_s6_uh;
    t_carry      r_s6_c;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[5]) begin
            r_s6_ul <= r_s5_tmag[31:0] * i_cfg.drag;
            r_s6_uh <= r_s5_tmag[48:32] * i_cfg.drag;
            r_s6_c  <= r_s5_c;
        end
    end

    // stage 7
    logic [50:0] r_s7_u;
    t_carry      r_s7_c;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[6]) begin
            r_s7_u <= {1'b0, r_s6_uh, 16'd0} + {18'd0, r_s6_ul[48:16]};
            r_s7_c <= r_s6_c;
        end
    end

    // stage 8: apply friction, clamp y
    logic [WIDE_W-1:0] s8_u, s8_adj;
    logic [31:0]       r_s8_nx, r_s8_ny;
    t_carry            r_s8_c;

    assign s8_u   = {{(WIDE_W-51){1'b0}}, r_s7_u};
    assign s8_adj = r_s7_c.neg ? (sx32(r_s7_c.nx) + s8_u) : (sx32(r_s7_c.nx) - s8_u);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[7]) begin
            r_s8_nx <= r_s7_c.hi ? sat32(s8_adj) : r_s7_c.nx;
            r_s8_ny <= r_s7_c.lo ? i_cfg.box_top : (r_s7_c.hi ? r_s7_c.bot : r_s7_c.ny);
            r_s8_c  <= r_s7_c;
        end
    end

    // stage 9: clamp x, output register
    logic [WIDE_W-1:0] s9_nx, s9_left, s9_right;
    logic [31:0]       s9_next_x;
    logic [31:0]       r_s9_nx, r_s9_ny, r_s9_lx, r_s9_ly;

    assign s9_nx    = sx32(r_s8_nx);
    assign s9_left  = sx32(i_cfg.box_left);
    assign s9_right = {{(WIDE_W-33){r_s8_c.right[32]}}, r_s8_c.right};

    always_comb begin
        s9_next_x = r_s8_nx;
        if (r_s8_c.bnd) begin
            if ($signed(s9_nx) < $signed(s9_left)) begin
                s9_next_x = i_cfg.box_left;
            end else if ($signed(s9_nx) > $signed(s9_right)) begin
                s9_next_x = r_s8_c.right[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load[8]) begin
            r_s9_nx <= s9_next_x;
            r_s9_ny <= r_s8_ny;
            r_s9_lx <= r_s8_c.lx;
            r_s9_ly <= r_s8_c.ly;
        end
    end

    assign o_next_x = r_s9_nx;
    assign o_next_y = r_s9_ny;
    assign o_last_x = r_s9_lx;
    assign o_last_y = r_s9_ly;

endmodule
